// ===== src/button_click_event_detector_top_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_TOP_DEFINES_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define BCED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/bced_pkg.sv =====
package bced_pkg;

	localparam int TICK_WIDTH = 16;
	localparam int CFG_TICK_W = 16;
	localparam int DEB_W      = 8;
	localparam int REP_W      = 8;
	localparam int CMP_W      = (TICK_WIDTH > CFG_TICK_W) ? TICK_WIDTH : CFG_TICK_W;

	localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;
	localparam logic [REP_W-1:0]      REP_MAX  = '1;

	localparam logic [DEB_W-1:0]      DEBOUNCE_RST = 8'd3;
	localparam logic [CFG_TICK_W-1:0] SHORT_RST    = 16'd60;
	localparam logic [CFG_TICK_W-1:0] LONG_RST     = 16'd200;

	localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [1:0] CFG_SHORT    = 2'd1;
	localparam logic [1:0] CFG_LONG     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_PRESSED = 3'd1,
		ST_WAIT    = 3'd2,
		ST_AGAIN   = 3'd3,
		ST_LONG    = 3'd5
	} click_state_t;

	typedef struct packed {
		logic [DEB_W-1:0]      settle_len;
		logic [CFG_TICK_W-1:0] gap_len;
		logic [CFG_TICK_W-1:0] hold_len;
	} cfg_t;

	typedef struct packed {
		logic             raw_level_echo;
		logic             stable_level;
		logic             btn_down;
		logic             btn_up;
		logic             btn_again;
		logic             click_x1;
		logic             click_x2;
		logic             long_press_start;
		logic             long_held;
		logic [REP_W-1:0] click_count;
	} result_t;

endpackage

// ===== src/bced_core.sv =====
`include "button_click_event_detector_top_defines.svh"

module bced_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             raw_level,
	input  bced_pkg::cfg_t    cfg,
	output bced_pkg::result_t res
);
	import bced_pkg::*;

	click_state_t            state_q, state_nxt;
	logic [TICK_WIDTH-1:0]   tick_q, tick_inc, tick_nxt;
	logic [DEB_W-1:0]        dcnt_q, dcnt_nxt;
	logic [DEB_W:0]          dcnt_inc;
	logic                    deb_q, deb_nxt;
	logic [REP_W-1:0]        rep_q, rep_nxt, rep_sat;
	logic                    gt_long, gt_short, lt_short;
	logic [5:0]              evt_vec;

	// tick count and debounce
	always_comb begin
		tick_inc = tick_q;
		if (state_q != ST_IDLE && tick_q != TICK_MAX) begin
			tick_inc = tick_q + 1'b1;
		end
		deb_nxt  = deb_q;
		dcnt_nxt = '0;
		dcnt_inc = {1'b0, dcnt_q} + 1'b1;
		if (raw_level != deb_q) begin
			if (dcnt_inc >= {1'b0, cfg.settle_len}) begin
				deb_nxt = raw_level;
			end else begin
				dcnt_nxt = dcnt_inc[DEB_W-1:0];
			end
		end
	end

	assign gt_long  = CMP_W'(tick_inc) > CMP_W'(cfg.hold_len);
	assign gt_short = CMP_W'(tick_inc) > CMP_W'(cfg.gap_len);
	assign lt_short = CMP_W'(tick_inc) < CMP_W'(cfg.gap_len);
	assign rep_sat  = (rep_q != REP_MAX) ? rep_q + 1'b1 : rep_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		tick_nxt  = tick_inc;
		rep_nxt   = rep_q;
		case (state_q)
			ST_IDLE: begin
				if (deb_nxt) begin
					tick_nxt  = '0;
					rep_nxt   = REP_W'(1);
					state_nxt = ST_PRESSED;
				end
			end
			ST_PRESSED: begin
				if (!deb_nxt) begin
					tick_nxt  = '0;
					state_nxt = ST_WAIT;
				end else if (gt_long) begin
					state_nxt = ST_LONG;
				end
			end
			ST_WAIT: begin
				if (deb_nxt) begin
					rep_nxt   = rep_sat;
					tick_nxt  = '0;
					state_nxt = ST_AGAIN;
				end else if (gt_short) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_AGAIN: begin
				if (!deb_nxt) begin
					if (lt_short) begin
						tick_nxt  = '0;
						state_nxt = ST_WAIT;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_LONG: begin
				if (!deb_nxt) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	// event flags
	always_comb begin
		res                = '0;
		res.raw_level_echo = raw_level;
		res.stable_level   = deb_nxt;
		res.click_count    = rep_nxt;
		case (state_q)
			ST_IDLE: begin
				res.btn_down = deb_nxt;
			end
			ST_PRESSED: begin
				res.btn_up           = !deb_nxt;
				res.long_press_start = deb_nxt && gt_long;
			end
			ST_WAIT: begin
				res.btn_down  = deb_nxt;
				res.btn_again = deb_nxt;
				res.click_x1  = !deb_nxt && gt_short && (rep_q == REP_W'(1));
				res.click_x2  = !deb_nxt && gt_short && (rep_q == REP_W'(2));
			end
			ST_AGAIN: begin
				res.btn_up = !deb_nxt;
			end
			ST_LONG: begin
				res.long_held = deb_nxt;
				res.btn_up    = !deb_nxt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q  <= '0;
			dcnt_q  <= '0;
			deb_q   <= 1'b0;
			rep_q   <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
			tick_q  <= tick_nxt;
			dcnt_q  <= dcnt_nxt;
			deb_q   <= deb_nxt;
			rep_q   <= rep_nxt;
		end
	end

	assign evt_vec = {res.btn_down, res.btn_up, res.click_x1, res.click_x2,
		res.long_press_start, res.long_held};

	`BCED_ASSERT_IMPL(a_flags_excl, clk, arst_n, accept, $onehot0(evt_vec))
	`BCED_ASSERT_IMPL(a_repeat_down, clk, arst_n, accept && res.btn_again, res.btn_down)
	`BCED_ASSERT_NEXT(a_down_enter, clk, arst_n, accept && res.btn_down, (state_q == ST_PRESSED || state_q == ST_AGAIN) && tick_q == '0)
	`BCED_ASSERT_IMPL(a_long_hold, clk, arst_n, accept && state_q == ST_LONG && res.stable_level, res.long_held)

endmodule

// ===== src/bced_out.sv =====
`include "button_click_event_detector_top_defines.svh"

module bced_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bced_pkg::result_t res,
	output logic             out_valid,
	input  logic             out_stall,
	output bced_pkg::result_t res_q
);
	import bced_pkg::*;

	logic valid_q;
	logic accept;

	assign in_stall  = valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	`BCED_ASSERT_NEXT(a_acc_valid, clk, arst_n, accept, valid_q)
	`BCED_ASSERT_NEXT(a_hold_valid, clk, arst_n, valid_q && out_stall, valid_q)
	`BCED_ASSERT_NEXT(a_drain, clk, arst_n, valid_q && !out_stall && !accept, !valid_q)

endmodule

// ===== src/button_click_event_detector_top.sv =====
// Button click event detector.
// Input channel: in_valid / in_stall carry one raw_level sample per item,
// one item per sampling tick. Output channel: out_valid / out_stall carry
// one result item per input item: the echoed sample, the debounced level,
// one-tick event flags and the current click count.
// Latency: an item's result is presented the cycle after it is accepted,
// from the output register. Throughput: one item per clock if unstalled.
// in_stall is high only while a result is held in the output register
// and out_stall is high; a result taken in the same cycle frees the
// register for the next item.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 debounce ticks, 1 short ticks, 2 long ticks); write only when idle.
// Reset: clears the click state, counters and the output valid, and
// loads debounce 3, short 60, long 200.
module button_click_event_detector_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              raw_level,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              raw_level_echo,
	output logic                              stable_level,
	output logic                              btn_down,
	output logic                              btn_up,
	output logic                              btn_again,
	output logic                              click_x1,
	output logic                              click_x2,
	output logic                              long_press_start,
	output logic                              long_held,
	output logic [bced_pkg::REP_W-1:0]        click_count,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [bced_pkg::CFG_TICK_W-1:0]   cfg_data
);
	import bced_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	result_t res_q;
	logic    accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_len <= DEBOUNCE_RST;
			cfg_q.gap_len    <= SHORT_RST;
			cfg_q.hold_len   <= LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: cfg_q.settle_len <= cfg_data[DEB_W-1:0];
				CFG_SHORT:    cfg_q.gap_len    <= cfg_data;
				CFG_LONG:     cfg_q.hold_len   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign accept = in_valid && !in_stall;

	bced_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.raw_level (raw_level),
		.cfg       (cfg_q),
		.res       (res)
	);

	bced_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign raw_level_echo   = res_q.raw_level_echo;
	assign stable_level     = res_q.stable_level;
	assign btn_down         = res_q.btn_down;
	assign btn_up           = res_q.btn_up;
	assign btn_again        = res_q.btn_again;
	assign click_x1         = res_q.click_x1;
	assign click_x2         = res_q.click_x2;
	assign long_press_start = res_q.long_press_start;
	assign long_held        = res_q.long_held;
	assign click_count      = res_q.click_count;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bced_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 40;
	localparam int PRINT_LIMIT = 100;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		logic            lvl;
		logic [1:0]      idx;
		logic [15:0]     data;
		bit              known;
		logic [8:0]      flags;
		logic [REP_W-1:0] count;
	} dir_row_t;

	typedef struct {
		logic [DEB_W-1:0]      deb;
		logic [CFG_TICK_W-1:0] shrt;
		logic [CFG_TICK_W-1:0] lng;
		int                    budget;
		bit                    hold_off;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic raw_level;
	logic out_valid;
	logic out_stall;
	logic raw_level_echo;
	logic stable_level;
	logic btn_down;
	logic btn_up;
	logic btn_again;
	logic click_x1;
	logic click_x2;
	logic long_press_start;
	logic long_held;
	logic [REP_W-1:0] click_count;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_TICK_W-1:0] cfg_data;

	cfg_t                  model_cfg;
	click_state_t          model_state;
	logic [TICK_WIDTH-1:0] model_tick;
	logic [DEB_W-1:0]      model_deb;
	logic                  model_level;
	logic [REP_W-1:0]      model_reps;

	result_t expected_events[$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      burst_left = 0;
	int      quiet_cycles = 0;
	bit      hold_off_req = 1'b0;

	dir_row_t directed [28];
	phase_t   phases [5];

	always #6 clk = ~clk;

	button_click_event_detector_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.raw_level        (raw_level),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.raw_level_echo   (raw_level_echo),
		.stable_level     (stable_level),
		.btn_down         (btn_down),
		.btn_up           (btn_up),
		.btn_again        (btn_again),
		.click_x1         (click_x1),
		.click_x2         (click_x2),
		.long_press_start (long_press_start),
		.long_held        (long_held),
		.click_count      (click_count),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	function automatic result_t predict_tick(input logic lvl);
		result_t r;
		logic [DEB_W:0] next_cnt;
		r = '0;
		if (model_state != ST_IDLE && model_tick != TICK_MAX)
			model_tick = model_tick + 1'b1;
		if (lvl != model_level) begin
			next_cnt = {1'b0, model_deb} + 1'b1;
			if (next_cnt >= {1'b0, model_cfg.settle_len}) begin
				model_level = lvl;
				model_deb = '0;
			end else begin
				model_deb = next_cnt[DEB_W-1:0];
			end
		end else begin
			model_deb = '0;
		end
		case (model_state)
			ST_IDLE: begin
				if (model_level) begin
					r.btn_down = 1'b1;
					model_tick = '0;
					model_reps = 1;
					model_state = ST_PRESSED;
				end
			end
			ST_PRESSED: begin
				if (!model_level) begin
					r.btn_up = 1'b1;
					model_tick = '0;
					model_state = ST_WAIT;
				end else if (model_tick > model_cfg.hold_len) begin
					r.long_press_start = 1'b1;
					model_state = ST_LONG;
				end
			end
			ST_WAIT: begin
				if (model_level) begin
					r.btn_down = 1'b1;
					r.btn_again = 1'b1;
					if (model_reps != REP_MAX)
						model_reps = model_reps + 1'b1;
					model_tick = '0;
					model_state = ST_AGAIN;
				end else if (model_tick > model_cfg.gap_len) begin
					r.click_x1 = (model_reps == 1);
					r.click_x2 = (model_reps == 2);
					model_state = ST_IDLE;
				end
			end
			ST_AGAIN: begin
				if (!model_level) begin
					r.btn_up = 1'b1;
					if (model_tick < model_cfg.gap_len) begin
						model_tick = '0;
						model_state = ST_WAIT;
					end else begin
						model_state = ST_IDLE;
					end
				end
			end
			ST_LONG: begin
				if (model_level) begin
					r.long_held = 1'b1;
				end else begin
					r.btn_up = 1'b1;
					model_state = ST_IDLE;
				end
			end
			default: ;
		endcase
		r.raw_level_echo = lvl;
		r.stable_level = model_level;
		r.click_count = model_reps;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatches < PRINT_LIMIT)
			$display("tb: mismatch on %s at result %0d: got %0d, expected %0d",
				what, results_seen, got, want);
		mismatches++;
	endtask

	// called at a falling edge, returns at a falling edge after acceptance
	task automatic send_level(input logic lvl, input bit known = 1'b0,
			input result_t typed = '0);
		int gap;
		result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 16);
		end
		predicted = predict_tick(lvl);
		expected_events.push_back(known ? typed : predicted);
		in_valid <= 1'b1;
		raw_level <= lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_events.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_TICK_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_DEBOUNCE: model_cfg.settle_len = data[DEB_W-1:0];
			CFG_SHORT:    model_cfg.gap_len = data;
			CFG_LONG:     model_cfg.hold_len = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [DEB_W-1:0] deb,
			input logic [CFG_TICK_W-1:0] shrt, input logic [CFG_TICK_W-1:0] lng);
		drain();
		write_reg(CFG_DEBOUNCE, {8'd0, deb});
		write_reg(CFG_SHORT, shrt);
		write_reg(CFG_LONG, lng);
	endtask

	// release until the click sequence has timed out
	task automatic settle();
		while (model_state != ST_IDLE || model_level != 1'b0)
			send_level(1'b0);
	endtask

	task automatic random_run(input int budget);
		int sent;
		int len;
		int glitch;
		int eff;
		int shrt;
		int lng;
		logic lvl;
		sent = 0;
		lvl = model_level;
		eff = (model_cfg.settle_len == 0) ? 1 : int'(model_cfg.settle_len);
		shrt = int'(model_cfg.gap_len);
		lng = int'(model_cfg.hold_len);
		while (sent < budget) begin
			if ($urandom_range(0, 9) < 2) begin
				len = $urandom_range(1, 8);
				repeat (len) send_level($urandom_range(0, 1) == 1);
				sent += len;
			end else begin
				lvl = !lvl;
				case ($urandom_range(0, 4))
					0: len = eff + $urandom_range(0, 2);
					1: len = eff + shrt - 2 + $urandom_range(0, 4);
					2: len = eff + lng - 1 + $urandom_range(0, 3);
					3: len = eff + $urandom_range(0, shrt + lng + 4);
					default: len = $urandom_range(1, eff);
				endcase
				if (len < 1)
					len = 1;
				glitch = (eff > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, eff - 1) : 0;
				repeat (len / 2) send_level(lvl);
				repeat (glitch) send_level(!lvl);
				repeat (len - len / 2) send_level(lvl);
				sent += len + glitch;
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {raw_level_echo, stable_level, btn_down, btn_up, btn_again,
				click_x1, click_x2, long_press_start, long_held, click_count};
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected item", got, 0);
			end else begin
				want = expected_events.pop_front();
				if (got.raw_level_echo !== want.raw_level_echo)
					report_mismatch("raw_level_echo", got.raw_level_echo, want.raw_level_echo);
				if (got.stable_level !== want.stable_level)
					report_mismatch("stable_level", got.stable_level, want.stable_level);
				if (got.btn_down !== want.btn_down)
					report_mismatch("btn_down", got.btn_down, want.btn_down);
				if (got.btn_up !== want.btn_up)
					report_mismatch("btn_up", got.btn_up, want.btn_up);
				if (got.btn_again !== want.btn_again)
					report_mismatch("btn_again", got.btn_again, want.btn_again);
				if (got.click_x1 !== want.click_x1)
					report_mismatch("click_x1", got.click_x1, want.click_x1);
				if (got.click_x2 !== want.click_x2)
					report_mismatch("click_x2", got.click_x2, want.click_x2);
				if (got.long_press_start !== want.long_press_start)
					report_mismatch("long_press_start", got.long_press_start,
						want.long_press_start);
				if (got.long_held !== want.long_held)
					report_mismatch("long_held", got.long_held, want.long_held);
				if (got.click_count !== want.click_count)
					report_mismatch("click_count", got.click_count, want.click_count);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : receiver
		int mode;
		int left;
		mode = 0;
		left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(5, 60);
				end
				left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					2: out_stall <= ($urandom_range(0, 4) == 0);
					default: out_stall <= (left % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		raw_level = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEBOUNCE;
		cfg_data = '0;
		arst_n = 1'b0;
		model_cfg = '{settle_len: DEBOUNCE_RST, gap_len: SHORT_RST,
			hold_len: LONG_RST};
		model_state = ST_IDLE;
		model_tick = '0;
		model_deb = '0;
		model_level = 1'b0;
		model_reps = '0;

		// flags: echo, stable, down, up, repeat, single, double, long start, long hold
		directed = '{
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b1, 9'b100000000, 8'd0},
			'{ROW_CFG,  1'b0, CFG_DEBOUNCE, 16'd1, 1'b0, 9'd0, 8'd0},
			'{ROW_CFG,  1'b0, CFG_SHORT,    16'd2, 1'b0, 9'd0, 8'd0},
			'{ROW_CFG,  1'b0, CFG_LONG,     16'd2, 1'b0, 9'd0, 8'd0},
			// double click
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b1, 9'b111000000, 8'd1},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b1, 9'b000000100, 8'd2},
			// single click
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			// long press
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b1, 9'b110000010, 8'd1},
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			// second press held too long, no click
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b1, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0},
			'{ROW_ITEM, 1'b0, CFG_DEBOUNCE, 16'd0, 1'b0, 9'd0, 8'd0}
		};

		phases = '{
			'{8'd3,   16'd60, 16'd200, 150, 1'b0},
			'{8'd0,   16'd0,  16'd0,   100, 1'b0},
			'{8'd1,   16'd5,  16'd10,  150, 1'b1},
			'{8'd2,   16'd20, 16'd40,  150, 1'b0},
			'{8'd255, 16'd3,  16'd4,   100, 1'b0}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				drain();
				write_reg(directed[i].idx, directed[i].data);
			end else begin
				send_level(directed[i].lvl, directed[i].known,
					{directed[i].flags, directed[i].count});
			end
		end
		settle();

		foreach (phases[i]) begin
			set_config(phases[i].deb, phases[i].shrt, phases[i].lng);
			if (phases[i].hold_off)
				hold_off_req = 1'b1;
			random_run(phases[i].budget);
			settle();
		end

		// click count saturation, then a timeout with no click
		set_config(8'd1, 16'd8, 16'd100);
		send_level(1'b1);
		repeat (260) begin
			send_level(1'b0);
			send_level(1'b1);
		end
		settle();

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
